>>> hw/rtl/gnp_pkg.sv
package gnp_pkg;

  localparam int MaxFciDef  = 256;
  localparam int WindowBits = 16;
  localparam int AddrWidth  = 4;

  typedef enum logic [1:0] {
    RegRepairEnable  = 2'd0,
    RegPolicerEnable = 2'd1,
    RegSeqOffset     = 2'd2,
    RegMaxEntries    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    KindEntry   = 1'b0,
    KindSummary = 1'b1
  } kind_e;

  typedef struct packed {
    logic        repair_enable;
    logic        policer_enable;
    logic [15:0] seq_offset;
    logic [8:0]  max_entries;
  } cfg_t;

  typedef struct packed {
    kind_e                   kind;
    logic [15:0]             pid;
    logic [WindowBits-1:0]   bitmask;
    logic [8:0]              entry_count;
    logic [31:0]             admitted_count;
    logic [31:0]             rejected_count;
    logic                    suppressed;
    logic                    is_last;
  } res_t;

  typedef struct packed {
    res_t [2:0] word;
    logic [1:0] count;
  } res_set_t;

endpackage

>>> hw/rtl/gnp_apb_regs.sv
module gnp_apb_regs
  import gnp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repair_enable  <= 1'b0;
      cfg_q.policer_enable <= 1'b0;
      cfg_q.seq_offset     <= 16'd0;
      cfg_q.max_entries    <= 9'd256;
    end else if (wr_en) begin
      unique case (idx)
        RegRepairEnable:  cfg_q.repair_enable  <= pwdata[0];
        RegPolicerEnable: cfg_q.policer_enable <= pwdata[0];
        RegSeqOffset:     cfg_q.seq_offset     <= pwdata[15:0];
        RegMaxEntries:    cfg_q.max_entries    <= pwdata[8:0];
        default:          cfg_q.max_entries    <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegRepairEnable:  prdata = {31'd0, cfg_q.repair_enable};
      RegPolicerEnable: prdata = {31'd0, cfg_q.policer_enable};
      RegSeqOffset:     prdata = {16'd0, cfg_q.seq_offset};
      RegMaxEntries:    prdata = {23'd0, cfg_q.max_entries};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/gnp_pack.sv
module gnp_pack
  import gnp_pkg::*;
#(
  parameter int MAX_FCI = MaxFciDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] seq_num_i,
  input  logic        has_seq_i,
  input  logic        first_of_report_i,
  input  logic        last_of_report_i,
  input  logic [15:0] tokens_available_i,
  input  logic        buf_free_i,
  output logic        push_o,
  output res_set_t    set_o
);

  localparam logic [8:0] FciLimit = 9'(MAX_FCI);

  logic        stg_valid_q;
  logic [31:0] seq_q;
  logic        has_seq_q;
  logic        first_q;
  logic        last_q;
  logic [15:0] tokens_av_q;

  logic [31:0]           open_pid_q, open_pid_d;
  logic [WindowBits-1:0] open_mask_q, open_mask_d;
  logic                  pid_open_q, pid_open_d;
  logic [8:0]            entries_q, entries_d;
  logic [31:0]           admitted_q, admitted_d;
  logic [31:0]           policed_q, policed_d;
  logic [15:0]           tokens_q, tokens_d;
  logic                  ovf_q, ovf_d;

  logic [8:0]  limit;
  logic        admit;
  logic [31:0] seq_gap;
  logic [31:0] seq_gap_m1;
  logic        emit_a, emit_b;
  res_t        res_a, res_b, res_c;
  logic        fire;

  assign limit = (cfg_i.max_entries > FciLimit) ? FciLimit : cfg_i.max_entries;

  always_comb begin
    open_pid_d  = first_q ? 32'd0 : open_pid_q;
    open_mask_d = first_q ? '0 : open_mask_q;
    pid_open_d  = first_q ? 1'b0 : pid_open_q;
    entries_d   = first_q ? 9'd0 : entries_q;
    admitted_d  = first_q ? 32'd0 : admitted_q;
    policed_d   = first_q ? 32'd0 : policed_q;
    ovf_d       = first_q ? 1'b0 : ovf_q;
    tokens_d    = first_q ? tokens_av_q : tokens_q;
    admit      = 1'b0;
    seq_gap    = seq_q - open_pid_d;
    seq_gap_m1 = seq_gap - 32'd1;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    res_a   = '0;
    res_b   = '0;
    res_c   = '0;
    res_a.kind = KindEntry;
    res_b.kind = KindEntry;
    res_c.kind = KindSummary;
    res_c.is_last = 1'b1;

    if (has_seq_q && cfg_i.repair_enable && !ovf_d) begin
      admit = 1'b1;
      if (cfg_i.policer_enable) begin
        if (tokens_d != 16'd0) begin
          tokens_d = tokens_d - 16'd1;
        end else begin
          if (policed_d != 32'hFFFF_FFFF) policed_d = policed_d + 32'd1;
          admit = 1'b0;
        end
      end
      if (admit) begin
        if (entries_d >= limit) begin
          ovf_d = 1'b1;
        end else begin
          if (admitted_d != 32'hFFFF_FFFF) admitted_d = admitted_d + 32'd1;
          if (!pid_open_d) begin
            open_pid_d  = seq_q;
            open_mask_d = '0;
            pid_open_d  = 1'b1;
          end else if (seq_gap == 32'd0) begin
            open_mask_d = open_mask_d;
          end else if (seq_gap <= 32'(WindowBits)) begin
            open_mask_d = open_mask_d | (WindowBits'(1) << seq_gap_m1[3:0]);
          end else begin
            emit_a        = 1'b1;
            res_a.pid     = open_pid_d[15:0] - cfg_i.seq_offset;
            res_a.bitmask = open_mask_d;
            res_a.is_last = !last_q;
            entries_d     = entries_d + 9'd1;
            open_pid_d    = seq_q;
            open_mask_d   = '0;
          end
        end
      end
    end

    if (last_q) begin
      if (!cfg_i.repair_enable) begin
        res_c.suppressed = 1'b0;
      end else if (ovf_d || (pid_open_d && entries_d >= limit)) begin
        res_c.suppressed     = 1'b1;
        res_c.rejected_count = policed_d;
      end else begin
        if (pid_open_d) begin
          emit_b        = 1'b1;
          res_b.pid     = open_pid_d[15:0] - cfg_i.seq_offset;
          res_b.bitmask = open_mask_d;
          entries_d     = entries_d + 9'd1;
        end
        res_c.entry_count    = entries_d;
        res_c.admitted_count = admitted_d;
        res_c.rejected_count = policed_d;
      end
      open_pid_d  = 32'd0;
      open_mask_d = '0;
      pid_open_d  = 1'b0;
      entries_d   = 9'd0;
      admitted_d  = 32'd0;
      policed_d   = 32'd0;
      ovf_d       = 1'b0;
    end
  end

  always_comb begin
    set_o       = '0;
    set_o.count = 2'd0;
    if (emit_a) begin
      set_o.word[set_o.count] = res_a;
      set_o.count = set_o.count + 2'd1;
    end
    if (emit_b) begin
      set_o.word[set_o.count] = res_b;
      set_o.count = set_o.count + 2'd1;
    end
    if (last_q) begin
      set_o.word[set_o.count] = res_c;
      set_o.count = set_o.count + 2'd1;
    end
  end

  assign fire       = stg_valid_q && (buf_free_i || set_o.count == 2'd0);
  assign push_o     = fire && set_o.count != 2'd0;
  assign in_ready_o = !stg_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      seq_q       <= seq_num_i;
      has_seq_q   <= has_seq_i;
      first_q     <= first_of_report_i;
      last_q      <= last_of_report_i;
      tokens_av_q <= tokens_available_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_pid_q  <= 32'd0;
      open_mask_q <= '0;
      pid_open_q  <= 1'b0;
      entries_q   <= 9'd0;
      admitted_q  <= 32'd0;
      policed_q   <= 32'd0;
      tokens_q    <= 16'd0;
      ovf_q       <= 1'b0;
    end else if (fire) begin
      open_pid_q  <= open_pid_d;
      open_mask_q <= open_mask_d;
      pid_open_q  <= pid_open_d;
      entries_q   <= entries_d;
      admitted_q  <= admitted_d;
      policed_q   <= policed_d;
      tokens_q    <= tokens_d;
      ovf_q       <= ovf_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= FciLimit)
    else $error("entry count ran past the limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !first_q |=> tokens_q <= $past(tokens_q))
    else $error("tokens grew within a report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_q |=> !pid_open_q && entries_q == 9'd0 && !ovf_q)
    else $error("report state not cleared on close");

endmodule

>>> hw/rtl/gnp_out_buf.sv
module gnp_out_buf
  import gnp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  res_set_t set_i,
  output logic     free_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output res_t     word_o
);

  res_t [2:0] word_q;
  logic [1:0] count_q;
  logic [1:0] idx_q;
  logic       out_fire;

  assign out_valid_o = idx_q != count_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (out_ready_i && idx_q == count_q - 2'd1);

  always_comb begin
    unique case (idx_q)
      2'd0:    word_o = word_q[0];
      2'd1:    word_o = word_q[1];
      default: word_o = word_q[2];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      idx_q   <= 2'd0;
    end else if (push_i) begin
      count_q <= set_i.count;
      idx_q   <= 2'd0;
    end else if (out_fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      word_q <= set_i.word;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q)
    else $error("read index beyond the loaded words");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o)
    else $error("result set loaded over undelivered words");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && word_o.is_last && !push_i |=> !out_valid_o)
    else $error("words left after the final word of an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_o.kind == KindSummary |-> word_o.is_last)
    else $error("summary not marked as the final word");

endmodule

>>> hw/rtl/generic_nack_packer_with_policer_core.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | seq_num, has_seq, first/last_of_report, tokens
// out     | output    | out_valid_o/out_ready_i| kind, pid, bitmask, counts, suppressed, is_last
// cfg     | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// An item is taken into the input register, processed combinationally and its words
// (up to three) are loaded into the result buffer, which sends one word a cycle while
// out_ready_i is high. A new item is accepted every cycle while items give at most one
// word each and the output does not stall; otherwise the result buffer sets the rate.
// Reset is asynchronous and clears all report state and tokens and sets the registers to their reset values.
// A stalled output holds the buffer and, once the next item needs it, the input.
module generic_nack_packer_with_policer_core
  import gnp_pkg::*;
#(
  parameter int MAX_FCI = MaxFciDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          seq_num_i,
  input  logic                 has_seq_i,
  input  logic                 first_of_report_i,
  input  logic                 last_of_report_i,
  input  logic [15:0]          tokens_available_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 kind_o,
  output logic [15:0]          pid_o,
  output logic [15:0]          bitmask_o,
  output logic [8:0]           entry_count_o,
  output logic [31:0]          admitted_count_o,
  output logic [31:0]          rejected_count_o,
  output logic                 suppressed_o,
  output logic                 is_last_o
);

  cfg_t     cfg;
  res_set_t set;
  logic     push;
  logic     buf_free;
  res_t     word;

  gnp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gnp_pack #(
    .MAX_FCI (MAX_FCI)
  ) u_pack (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .seq_num_i          (seq_num_i),
    .has_seq_i          (has_seq_i),
    .first_of_report_i  (first_of_report_i),
    .last_of_report_i   (last_of_report_i),
    .tokens_available_i (tokens_available_i),
    .buf_free_i         (buf_free),
    .push_o             (push),
    .set_o              (set)
  );

  gnp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .set_i       (set),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_o      (word)
  );

  assign kind_o           = word.kind;
  assign pid_o            = word.pid;
  assign bitmask_o        = word.bitmask;
  assign entry_count_o    = word.entry_count;
  assign admitted_count_o = word.admitted_count;
  assign rejected_count_o = word.rejected_count;
  assign suppressed_o     = word.suppressed;
  assign is_last_o        = word.is_last;

endmodule

>>> verif/generic_nack_packer_with_policer_core_test.sv
`timescale 1ns / 1ps

module generic_nack_packer_with_policer_core_test;
  import gnp_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 10;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [31:0]          seq_num_i = '0;
  logic                 has_seq_i = 1'b0;
  logic                 first_of_report_i = 1'b0;
  logic                 last_of_report_i = 1'b0;
  logic [15:0]          tokens_available_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 kind_o;
  logic [15:0]          pid_o;
  logic [15:0]          bitmask_o;
  logic [8:0]           entry_count_o;
  logic [31:0]          admitted_count_o;
  logic [31:0]          rejected_count_o;
  logic                 suppressed_o;
  logic                 is_last_o;

  typedef struct packed {
    logic [31:0] seq;
    logic        has_seq;
    logic        first;
    logic        last;
    logic [15:0] tokens;
  } lost_seq_t;

  generic_nack_packer_with_policer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .seq_num_i          (seq_num_i),
    .has_seq_i          (has_seq_i),
    .first_of_report_i  (first_of_report_i),
    .last_of_report_i   (last_of_report_i),
    .tokens_available_i (tokens_available_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .pid_o              (pid_o),
    .bitmask_o          (bitmask_o),
    .entry_count_o      (entry_count_o),
    .admitted_count_o   (admitted_count_o),
    .rejected_count_o   (rejected_count_o),
    .suppressed_o       (suppressed_o),
    .is_last_o          (is_last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  cfg_t        cfg = '{repair_enable: 1'b0, policer_enable: 1'b0, seq_offset: 16'd0,
                       max_entries: 9'd256};
  logic [31:0] run_pid = '0;
  logic [15:0] run_mask = '0;
  logic        run_active = 1'b0;
  logic [8:0]  entries_sent = '0;
  logic [31:0] admitted_cnt = '0;
  logic [31:0] policed_cnt = '0;
  logic [15:0] token_bal = '0;
  logic        over_limit = 1'b0;

  lost_seq_t pending_seqs[$];
  lost_seq_t on_bus;
  res_t      expected_words[$];
  int        seqs_in_flight = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;
  int        quiet_cycles = 0;

  function automatic void clear_report();
    run_pid = '0;
    run_mask = '0;
    run_active = 1'b0;
    entries_sent = '0;
    admitted_cnt = '0;
    policed_cnt = '0;
    over_limit = 1'b0;
  endfunction

  function automatic res_t close_entry();
    res_t w;
    w = '0;
    w.kind = KindEntry;
    w.pid = run_pid[15:0] - cfg.seq_offset;
    w.bitmask = run_mask;
    entries_sent = entries_sent + 9'd1;
    return w;
  endfunction

  task automatic pack_lost_seq(input lost_seq_t it);
    res_t        words[$];
    res_t        w;
    logic [31:0] gap;
    logic        admit;
    int unsigned lim;
    lim = (cfg.max_entries < MaxFciDef) ? cfg.max_entries : MaxFciDef;
    if (it.first) begin
      clear_report();
      token_bal = it.tokens;
    end
    if (it.has_seq && cfg.repair_enable && !over_limit) begin
      admit = 1'b1;
      if (cfg.policer_enable) begin
        if (token_bal != 0) begin
          token_bal = token_bal - 16'd1;
        end else begin
          if (policed_cnt != 32'hFFFF_FFFF) policed_cnt = policed_cnt + 32'd1;
          admit = 1'b0;
        end
      end
      if (admit) begin
        if (entries_sent >= lim) begin
          over_limit = 1'b1;
        end else begin
          if (admitted_cnt != 32'hFFFF_FFFF) admitted_cnt = admitted_cnt + 32'd1;
          if (!run_active) begin
            run_pid = it.seq;
            run_mask = '0;
            run_active = 1'b1;
          end else begin
            gap = it.seq - run_pid;
            if (gap == 0) begin
              // A repeat of the entry start adds nothing to the mask.
            end else if (gap <= WindowBits) begin
              run_mask[gap - 1] = 1'b1;
            end else begin
              words.push_back(close_entry());
              run_pid = it.seq;
              run_mask = '0;
            end
          end
        end
      end
    end
    if (it.last) begin
      w = '0;
      w.kind = KindSummary;
      if (!cfg.repair_enable) begin
      end else if (over_limit || (run_active && entries_sent >= lim)) begin
        w.rejected_count = policed_cnt;
        w.suppressed = 1'b1;
      end else begin
        if (run_active) words.push_back(close_entry());
        w.entry_count = entries_sent;
        w.admitted_count = admitted_cnt;
        w.rejected_count = policed_cnt;
      end
      words.push_back(w);
      clear_report();
    end
    if (words.size() > 0) words[words.size() - 1].is_last = 1'b1;
    foreach (words[i]) expected_words.push_back(words[i]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pack_lost_seq(on_bus);
        seqs_in_flight--;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_seqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_seqs.pop_front();
          in_valid_i <= 1'b1;
          seq_num_i <= on_bus.seq;
          has_seq_i <= on_bus.has_seq;
          first_of_report_i <= on_bus.first;
          last_of_report_i <= on_bus.last;
          tokens_available_i <= on_bus.tokens;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {kind_o, pid_o, bitmask_o, entry_count_o, admitted_count_o, rejected_count_o,
               suppressed_o, is_last_o};
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("unexpected word %p", got);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.pid !== want.pid ||
              got.bitmask !== want.bitmask || got.entry_count !== want.entry_count ||
              got.admitted_count !== want.admitted_count ||
              got.rejected_count !== want.rejected_count ||
              got.suppressed !== want.suppressed || got.is_last !== want.is_last) begin
            if (errors < 10) $display("word mismatch: expected %p, got %p", want, got);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic queue_item(input logic [31:0] seq, input logic has_seq, input logic first,
                            input logic last, input logic [15:0] tokens);
    lost_seq_t it;
    it = '{seq: seq, has_seq: has_seq, first: first, last: last, tokens: tokens};
    pending_seqs.push_back(it);
    seqs_in_flight++;
  endtask

  task automatic settle();
    while (seqs_in_flight != 0 || expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegRepairEnable:  cfg.repair_enable = value[0];
      RegPolicerEnable: cfg.policer_enable = value[0];
      RegSeqOffset:     cfg.seq_offset = value[15:0];
      RegMaxEntries:    cfg.max_entries = value[8:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic repair, input logic police, input logic [15:0] offset,
                            input logic [8:0] max_entries);
    settle();
    apb_write(RegRepairEnable, 32'(repair));
    apb_write(RegPolicerEnable, 32'(police));
    apb_write(RegSeqOffset, 32'(offset));
    apb_write(RegMaxEntries, 32'(max_entries));
  endtask

  // Reports mostly walk forward inside the mask window, with repeats, window edges,
  // far jumps, backward steps, bare boundaries and the odd early close or restart.
  task automatic queue_report(input int n);
    logic [31:0] seq;
    logic        first, last;
    seq = ($urandom_range(0, 7) == 0) ? (32'hFFFF_FFF0 | 32'($urandom_range(0, 15)))
                                      : $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: seq = seq + $urandom_range(1, 16);
        5:             seq = seq;
        6:             seq = seq + $urandom_range(15, 18);
        7:             seq = seq + $urandom_range(17, 1000);
        8:             seq = $urandom;
        default:       seq = seq - $urandom_range(1, 16);
      endcase
      first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
      last = (i == n - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
      queue_item(seq, $urandom_range(0, 15) != 0, first, last,
                 $urandom_range(0, 1) ? 16'($urandom_range(0, n)) : 16'($urandom));
    end
  endtask

  task automatic run_phase(input logic repair, input logic police, input logic [15:0] offset,
                           input logic [8:0] max_entries, input int send_pct,
                           input int stall_pct, input int n_items);
    int queued;
    int n;
    set_config(repair, police, offset, max_entries);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queued = 0;
    while (queued < n_items) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      queue_report(n);
      queued += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(32'd5, 1'b1, 1'b1, 1'b1, 16'd0);
    queue_item(32'd6, 1'b1, 1'b0, 1'b0, 16'hFFFF);
    queue_item(32'd0, 1'b0, 1'b0, 1'b1, 16'd0);

    set_config(1'b1, 1'b0, 16'h0000, 9'd256);
    queue_item(32'd0, 1'b1, 1'b1, 1'b0, 16'hFFFF);
    queue_item(32'd16, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd0, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd17, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd18, 1'b1, 1'b0, 1'b1, 16'd0);
    queue_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'd0);
    queue_item(32'h0000_000F, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'h0000_0010, 1'b1, 1'b0, 1'b1, 16'd0);
    queue_item(32'hAAAA_5555, 1'b0, 1'b0, 1'b1, 16'd0);

    set_config(1'b1, 1'b1, 16'hFFFF, 9'd2);
    queue_item(32'd100, 1'b1, 1'b1, 1'b0, 16'd2);
    queue_item(32'd200, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd300, 1'b1, 1'b0, 1'b1, 16'd0);
    queue_item(32'd1, 1'b1, 1'b1, 1'b1, 16'd0);
    queue_item(32'd10, 1'b1, 1'b1, 1'b0, 16'hFFFF);
    queue_item(32'd1000, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd2000, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd3000, 1'b1, 1'b0, 1'b0, 16'd0);
    queue_item(32'd3001, 1'b1, 1'b0, 1'b1, 16'd0);

    set_config(1'b1, 1'b1, 16'h1234, 9'd0);
    queue_item(32'd7, 1'b1, 1'b1, 1'b1, 16'd3);

    set_config(1'b1, 1'b0, 16'h8000, 9'd1);
    queue_item(32'd5, 1'b1, 1'b1, 1'b0, 16'd0);
    queue_item(32'd50, 1'b1, 1'b0, 1'b1, 16'd0);
    queue_item(32'd9, 1'b1, 1'b0, 1'b1, 16'd0);

    run_phase(1'b1, 1'b0, 16'($urandom), 9'd256, 0, 0, 40);
    run_phase(1'b1, 1'b1, 16'($urandom), 9'd3, 52, 0, 40);
    run_phase(1'b1, 1'b0, 16'hFFFF, 9'd1, 0, 52, 35);
    run_phase(1'b1, 1'b1, 16'($urandom), 9'd511, 14, 14, 40);
    run_phase(1'b0, 1'b1, 16'd0, 9'd2, 14, 14, 10);
    run_phase(1'b1, 1'b1, 16'd0, 9'd2, 0, 0, 30);
    run_phase(1'b1, 1'b0, 16'($urandom), 9'd0, 52, 52, 10);
    settle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
